@@ hdl/nca_pkg.sv @@
package nca_pkg;

  localparam int COORD_FIELDS = 4;
  localparam int COORD_W      = 16;
  localparam int CLUSTER_ID_W = 3;
  localparam int LOAD_DIM_W   = 2;
  localparam int CLUSTERS_W   = 4;
  localparam int DIMS_W       = 3;
  localparam int APB_ADDR_W   = 3;
  localparam int APB_DATA_W   = 32;

  localparam logic [CLUSTERS_W-1:0] CLUSTERS_RESET = 4'd8;
  localparam logic [DIMS_W-1:0]     DIMS_RESET     = 3'd4;
  localparam logic [COORD_W-1:0]    SUM_START      = 16'hFFFF;

  // register index, taken from paddr[2]
  localparam logic REG_CLUSTERS = 1'b0;
  localparam logic REG_DIMS     = 1'b1;

  typedef enum logic {
    FUNC_LOAD     = 1'b0,
    FUNC_CLASSIFY = 1'b1
  } nca_func_t;

  typedef struct packed {
    logic [CLUSTERS_W-1:0] clusters;
    logic [DIMS_W-1:0]     dims;
  } nca_ctrl_t;

  typedef struct packed {
    nca_func_t                                func;
    logic [CLUSTER_ID_W-1:0]                  load_cluster;
    logic [LOAD_DIM_W-1:0]                    load_dim;
    logic [COORD_W-1:0]                       load_value;
    logic [COORD_FIELDS-1:0][COORD_W-1:0]     coord;
    logic [COORD_W-1:0]                       best_sum;
    logic [CLUSTER_ID_W-1:0]                  cluster_id;
  } nca_flow_t;

endpackage

@@ hdl/nca_item_if.sv @@
interface nca_item_if;
  import nca_pkg::*;

  logic                        valid;
  logic                        ready;
  logic                        func;
  logic [CLUSTER_ID_W-1:0]     load_cluster;
  logic [LOAD_DIM_W-1:0]       load_dim;
  logic [COORD_W-1:0]          load_value;
  logic [COORD_W-1:0]          coord_0;
  logic [COORD_W-1:0]          coord_1;
  logic [COORD_W-1:0]          coord_2;
  logic [COORD_W-1:0]          coord_3;

  modport source (
    output valid, func, load_cluster, load_dim, load_value,
           coord_0, coord_1, coord_2, coord_3,
    input  ready
  );

  modport sink (
    input  valid, func, load_cluster, load_dim, load_value,
           coord_0, coord_1, coord_2, coord_3,
    output ready
  );
endinterface

@@ hdl/nca_result_if.sv @@
interface nca_result_if;
  import nca_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [CLUSTER_ID_W-1:0] cluster_id;
  logic [COORD_W-1:0]      best_sum;

  modport source (output valid, cluster_id, best_sum, input ready);
  modport sink (input valid, cluster_id, best_sum, output ready);
endinterface

@@ hdl/nca_cell.sv @@
module nca_cell #(
  parameter int CLUSTER_INDEX = 0,
  parameter int CELL_DIMS     = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  nca_pkg::nca_ctrl_t ctrl,
  input  logic              valid_in,
  input  nca_pkg::nca_flow_t flow_in,
  output logic              valid_out,
  output nca_pkg::nca_flow_t flow_out
);
  import nca_pkg::*;

  logic [COORD_W-1:0] centroid [CELL_DIMS];
  logic [COORD_W-1:0] sum;
  logic               active;
  logic               load_hit;
  nca_flow_t          flow_next;

  always_comb begin
    sum = '0;
    for (int d = 0; d < CELL_DIMS; d++) begin
      if (d < int'(ctrl.dims)) begin
        sum = sum + flow_in.coord[d] - centroid[d];
      end
    end
  end

  assign active = (flow_in.func == FUNC_CLASSIFY) &&
                  (CLUSTER_INDEX < int'(ctrl.clusters));

  assign load_hit = en && valid_in && (flow_in.func == FUNC_LOAD) &&
                    (int'(flow_in.load_cluster) == CLUSTER_INDEX);

  // less-or-equal: ties go to the later cluster
  always_comb begin
    flow_next = flow_in;
    if (active && (sum <= flow_in.best_sum)) begin
      flow_next.best_sum   = sum;
      flow_next.cluster_id = CLUSTER_ID_W'(CLUSTER_INDEX);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (en) begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      flow_out <= flow_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int d = 0; d < CELL_DIMS; d++) begin
      if (load_hit && (int'(flow_in.load_dim) == d)) begin
        centroid[d] <= flow_in.load_value;
      end
    end
  end

endmodule

@@ hdl/nearest_centroid_assign.sv @@
// channel   role  transaction
// item      sink  load one centroid word (func 0) or classify one point (func 1)
// result    src   cluster_id and best_sum, one per classify transaction
// apb       cfg   clusters_in_use at 0x0, dims_in_use at 0x4
//
// One item per cycle unless the chain holds; a classify result passes through
// one cell per cluster, each in use comparing its centroid against the running best.
// Loads walk the same chain and write their cell on the way, so order holds.
// rst is synchronous: chain emptied, registers to 8 and 4; centroids not cleared.
// The whole chain holds while a result waits and result.ready is low.
module nearest_centroid_assign #(
  parameter int CLUSTERS = 8,
  parameter int DIMS     = 4
) (
  input  logic                                clk,
  input  logic                                rst,
  nca_item_if.sink                            item,
  nca_result_if.source                        result,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [nca_pkg::APB_ADDR_W-1:0]      paddr,
  input  logic [nca_pkg::APB_DATA_W-1:0]      pwdata,
  output logic [nca_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                pready
);
  import nca_pkg::*;

  localparam int DIM_TOP = (DIMS < COORD_FIELDS) ? DIMS : COORD_FIELDS;

  logic [CLUSTERS_W-1:0] clusters_in_use;
  logic [DIMS_W-1:0]     dims_in_use;
  nca_ctrl_t             ctrl;
  logic                  cfg_write;
  logic                  advance;
  logic                  valid [CLUSTERS+1];
  nca_flow_t             flow  [CLUSTERS+1];

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      clusters_in_use <= CLUSTERS_RESET;
      dims_in_use     <= DIMS_RESET;
    end else if (cfg_write) begin
      unique case (paddr[2])
        REG_CLUSTERS: clusters_in_use <= pwdata[CLUSTERS_W-1:0];
        REG_DIMS:     dims_in_use     <= pwdata[DIMS_W-1:0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_CLUSTERS: prdata = {{(APB_DATA_W-CLUSTERS_W){1'b0}}, clusters_in_use};
      REG_DIMS:     prdata = {{(APB_DATA_W-DIMS_W){1'b0}}, dims_in_use};
      default:      prdata = '0;
    endcase
  end

  always_comb begin
    if (clusters_in_use == '0) begin
      ctrl.clusters = CLUSTERS_W'(1);
    end else if (int'(clusters_in_use) > CLUSTERS) begin
      ctrl.clusters = CLUSTERS_W'(CLUSTERS);
    end else begin
      ctrl.clusters = clusters_in_use;
    end
    if (dims_in_use == '0) begin
      ctrl.dims = DIMS_W'(1);
    end else if (int'(dims_in_use) > DIM_TOP) begin
      ctrl.dims = DIMS_W'(DIM_TOP);
    end else begin
      ctrl.dims = dims_in_use;
    end
  end

  assign advance    = !result.valid || result.ready;
  assign item.ready = advance;

  assign valid[0]              = item.valid;
  assign flow[0].func          = nca_func_t'(item.func);
  assign flow[0].load_cluster  = item.load_cluster;
  assign flow[0].load_dim      = item.load_dim;
  assign flow[0].load_value    = item.load_value;
  assign flow[0].coord[0]      = item.coord_0;
  assign flow[0].coord[1]      = item.coord_1;
  assign flow[0].coord[2]      = item.coord_2;
  assign flow[0].coord[3]      = item.coord_3;
  assign flow[0].best_sum      = SUM_START;
  assign flow[0].cluster_id    = '0;

  for (genvar c = 0; c < CLUSTERS; c++) begin : g_cell
    nca_cell #(
      .CLUSTER_INDEX (c),
      .CELL_DIMS     (DIM_TOP)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (advance),
      .ctrl      (ctrl),
      .valid_in  (valid[c]),
      .flow_in   (flow[c]),
      .valid_out (valid[c+1]),
      .flow_out  (flow[c+1])
    );
  end

  assign result.valid      = valid[CLUSTERS] && (flow[CLUSTERS].func == FUNC_CLASSIFY);
  assign result.cluster_id = flow[CLUSTERS].cluster_id;
  assign result.best_sum   = flow[CLUSTERS].best_sum;

  a_clusters_range: assert property (@(posedge clk) disable iff (rst)
    (ctrl.clusters != '0) && (int'(ctrl.clusters) <= CLUSTERS))
    else $error("cluster count out of range");

  a_dims_range: assert property (@(posedge clk) disable iff (rst)
    (ctrl.dims != '0) && (int'(ctrl.dims) <= DIM_TOP))
    else $error("dimension count out of range");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !item.ready |=> result.valid && $stable(result.best_sum) &&
                    $stable(result.cluster_id))
    else $error("result lost while chain stalled");

  a_load_no_result: assert property (@(posedge clk) disable iff (rst)
    (valid[CLUSTERS] && (flow[CLUSTERS].func == FUNC_LOAD)) |-> !result.valid)
    else $error("load transaction produced a result");

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 100ps

module tb;
  import nca_pkg::*;

  localparam int CLUSTERS     = 8;
  localparam int DIMS         = 4;
  localparam int DIM_TOP      = (DIMS < COORD_FIELDS) ? DIMS : COORD_FIELDS;
  localparam int DRAIN_CYCLES = CLUSTERS + 4;
  localparam int IDLE_LIMIT   = 4000;
  localparam int HOLD_CYCLES  = 300;
  localparam int PHASE_ITEMS  = 130;
  localparam int PHASES       = 11;

  localparam int PHASE_CLUSTERS [PHASES] = '{8, 1, 0, 15, 8, 3, 9, 2, 7, 0, 15};
  localparam int PHASE_DIMS     [PHASES] = '{4, 1, 0, 7, 4, 2, 5, 3, 1, 7, 0};

  typedef struct packed {
    logic [CLUSTER_ID_W-1:0] cluster_id;
    logic [COORD_W-1:0]      best_sum;
  } assignment_t;

  class assignment_scoreboard;
    logic [COORD_W-1:0]    centroid [CLUSTERS][DIMS];
    logic [CLUSTERS_W-1:0] clusters_reg;
    logic [DIMS_W-1:0]     dims_reg;
    assignment_t           expected_q [$];
    int                    errors;

    function new();
      clusters_reg = CLUSTERS_RESET;
      dims_reg     = DIMS_RESET;
      errors       = 0;
    endfunction

    function void write_reg(logic idx, logic [APB_DATA_W-1:0] value);
      if (idx == REG_CLUSTERS) begin
        clusters_reg = value[CLUSTERS_W-1:0];
      end else begin
        dims_reg = value[DIMS_W-1:0];
      end
    endfunction

    // running minimum from 0xFFFF, replaced on <= so ties go to the later cluster
    function assignment_t nearest_centroid(nca_flow_t p);
      int nc, nd;
      logic [COORD_W-1:0] total;
      assignment_t best;
      nc = (clusters_reg == 0) ? 1 : (clusters_reg > CLUSTERS) ? CLUSTERS : int'(clusters_reg);
      nd = (dims_reg == 0) ? 1 : (dims_reg > DIM_TOP) ? DIM_TOP : int'(dims_reg);
      best.best_sum   = SUM_START;
      best.cluster_id = '0;
      for (int c = 0; c < nc; c++) begin
        total = '0;
        for (int d = 0; d < nd; d++) begin
          total = total + p.coord[d] - centroid[c][d];
        end
        if (total <= best.best_sum) begin
          best.best_sum   = total;
          best.cluster_id = CLUSTER_ID_W'(c);
        end
      end
      return best;
    endfunction

    function void note_item(nca_flow_t t);
      if (t.func == FUNC_LOAD) begin
        if (t.load_cluster < CLUSTERS && t.load_dim < DIMS) begin
          centroid[t.load_cluster][t.load_dim] = t.load_value;
        end
      end else begin
        expected_q.insert(expected_q.size(), nearest_centroid(t));
      end
    endfunction

    function void check_result(logic [CLUSTER_ID_W-1:0] id, logic [COORD_W-1:0] total);
      assignment_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result cluster_id %0d best_sum %h", $time, id, total);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (id !== want.cluster_id) begin
        $display("%0t: cluster_id expected %0d actual %0d", $time, want.cluster_id, id);
        errors++;
      end
      if (total !== want.best_sum) begin
        $display("%0t: best_sum expected %h actual %h", $time, want.best_sum, total);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  int idle_mode     = 0;
  int sink_busy_pct = 0;
  bit hold_request  = 1'b0;

  assignment_scoreboard sb = new();

  nca_item_if   item_ch ();
  nca_result_if result_ch ();

  nearest_centroid_assign #(
    .CLUSTERS (CLUSTERS),
    .DIMS     (DIMS)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .item    (item_ch),
    .result  (result_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  always @(posedge clk) begin : item_monitor
    nca_flow_t seen;
    if (!rst && item_ch.valid && item_ch.ready) begin
      seen              = '0;
      seen.func         = nca_func_t'(item_ch.func);
      seen.load_cluster = item_ch.load_cluster;
      seen.load_dim     = item_ch.load_dim;
      seen.load_value   = item_ch.load_value;
      seen.coord[0]     = item_ch.coord_0;
      seen.coord[1]     = item_ch.coord_1;
      seen.coord[2]     = item_ch.coord_2;
      seen.coord[3]     = item_ch.coord_3;
      sb.note_item(seen);
    end
  end

  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready) begin
      sb.check_result(result_ch.cluster_id, result_ch.best_sum);
    end
  end

  initial begin : result_sink
    forever begin
      if (hold_request) begin
        result_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
      end else if ($urandom_range(0, 99) < sink_busy_pct) begin
        result_ch.ready <= 1'b0;
        repeat (($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3))
          @(posedge clk);
      end else begin
        result_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready) || psel) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (idle_mode == 0) return 0;
    if (r < ((idle_mode == 1) ? 80 : 50)) return 0;
    if (r < 97) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [COORD_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return COORD_W'($urandom);
  endfunction

  // valid stays up on return so back-to-back transactions need no extra edge
  task automatic send_item(input nca_flow_t t);
    item_ch.valid        <= 1'b1;
    item_ch.func         <= t.func;
    item_ch.load_cluster <= t.load_cluster;
    item_ch.load_dim     <= t.load_dim;
    item_ch.load_value   <= t.load_value;
    item_ch.coord_0      <= t.coord[0];
    item_ch.coord_1      <= t.coord[1];
    item_ch.coord_2      <= t.coord[2];
    item_ch.coord_3      <= t.coord[3];
    do @(posedge clk); while (!item_ch.ready);
  endtask

  task automatic idle_gap(input int n);
    if (n > 0) begin
      item_ch.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic load_word(input int c, input int d, input logic [COORD_W-1:0] v);
    nca_flow_t t;
    t              = '0;
    t.func         = FUNC_LOAD;
    t.load_cluster = CLUSTER_ID_W'(c);
    t.load_dim     = LOAD_DIM_W'(d);
    t.load_value   = v;
    send_item(t);
    idle_gap(pick_gap());
  endtask

  task automatic classify_point(input logic [COORD_FIELDS-1:0][COORD_W-1:0] pt);
    nca_flow_t t;
    t       = '0;
    t.func  = FUNC_CLASSIFY;
    t.coord = pt;
    t.load_cluster = CLUSTER_ID_W'($urandom);
    t.load_dim     = LOAD_DIM_W'($urandom);
    t.load_value   = COORD_W'($urandom);
    send_item(t);
    idle_gap(pick_gap());
  endtask

  task automatic drain();
    item_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // leaves psel up so a following write needs no second assignment in the same step
  task automatic reg_write(input logic idx, input int value);
    logic [APB_DATA_W-1:0] data;
    data = $urandom;
    if (idx == REG_CLUSTERS) begin
      data[CLUSTERS_W-1:0] = CLUSTERS_W'(value);
    end else begin
      data[DIMS_W-1:0] = DIMS_W'(value);
    end
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.write_reg(idx, data);
  endtask

  task automatic set_config(input int clusters, input int dims);
    drain();
    reg_write(REG_CLUSTERS, clusters);
    reg_write(REG_DIMS, dims);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic random_items(input int n);
    int done_items, r, a, b;
    logic [COORD_FIELDS-1:0][COORD_W-1:0] pt;
    done_items = 0;
    while (done_items < n) begin
      r = $urandom_range(0, 99);
      if (r < 22) begin
        load_word($urandom_range(0, CLUSTERS - 1), $urandom_range(0, DIMS - 1), pick_value());
        done_items++;
      end else if (r < 27) begin
        // duplicate one centroid into another to provoke ties
        a = $urandom_range(0, CLUSTERS - 1);
        b = $urandom_range(0, CLUSTERS - 1);
        for (int d = 0; d < DIMS; d++) begin
          load_word(b, d, sb.centroid[a][d]);
        end
        done_items += DIMS;
      end else begin
        a = $urandom_range(0, CLUSTERS - 1);
        for (int d = 0; d < COORD_FIELDS; d++) begin
          if (r < 60) begin
            pt[d] = sb.centroid[a][d % DIMS] + (($urandom_range(0, 3) == 0) ? 16'd1 : 16'd0);
          end else if (r < 70) begin
            pt[d] = $urandom_range(0, 1) ? '1 : '0;
          end else begin
            pt[d] = COORD_W'($urandom);
          end
        end
        classify_point(pt);
        done_items++;
      end
    end
  endtask

  initial begin : stimulus
    logic [COORD_FIELDS-1:0][COORD_W-1:0] pt;
    rst                  <= 1'b1;
    psel                 <= 1'b0;
    penable              <= 1'b0;
    pwrite               <= 1'b0;
    paddr                <= '0;
    pwdata               <= '0;
    item_ch.valid        <= 1'b0;
    item_ch.func         <= FUNC_LOAD;
    item_ch.load_cluster <= '0;
    item_ch.load_dim     <= '0;
    item_ch.load_value   <= '0;
    item_ch.coord_0      <= '0;
    item_ch.coord_1      <= '0;
    item_ch.coord_2      <= '0;
    item_ch.coord_3      <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // whole store written before any classify; cluster 3 at the top value, the rest zero
    for (int c = 0; c < CLUSTERS; c++) begin
      for (int d = 0; d < DIMS; d++) begin
        load_word(c, d, (c == 3) ? 16'hFFFF : 16'h0000);
      end
    end
    classify_point({4{16'h0000}});
    classify_point({4{16'hFFFF}});
    classify_point({16'h0000, 16'h0000, 16'h0000, 16'hFFFF});
    classify_point({16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000});

    for (int p = 0; p < PHASES; p++) begin
      if (p != 0) set_config(PHASE_CLUSTERS[p], PHASE_DIMS[p]);
      idle_mode     = p % 3;
      sink_busy_pct = (idle_mode == 0) ? 0 : (idle_mode == 1) ? 20 : 50;
      if (p == 4 || p == 9) begin
        idle_mode    = 0;
        hold_request = 1'b1;
      end
      if (p == 1) begin
        // sum lands exactly on the starting minimum
        pt    = '0;
        pt[0] = sb.centroid[0][0] - 16'd1;
        classify_point(pt);
      end
      random_items(PHASE_ITEMS);
    end

    drain();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
